### rtl/core/aitc_pkg.sv
// Package for the address text classifier: decoded character record,
// class codes and sizing constants.
// No dependencies.
`default_nettype none

package aitc_pkg;

  // Result classes
  typedef enum logic [1:0] {
    CLASS_V4   = 2'd0,
    CLASS_V6   = 2'd1,
    CLASS_NONE = 2'd2
  } addr_class_t;

  // Depth of the queue between the front and the back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Segment state widths and saturation limits
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned VALUE_W   = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
  localparam logic [VALUE_W-1:0] V4_SEG_MAX = 10'd255;
  localparam logic [COUNT_W-1:0] V4_SEPS   = 4'd3;
  localparam logic [COUNT_W-1:0] V6_SEPS   = 4'd7;

  // Character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  // One classified character as it travels from front to back
  typedef struct packed {
    logic       is_dot;
    logic       is_colon;
    logic       is_digit;
    logic       is_hex;
    logic       is_zero;
    logic [3:0] digit;
    logic       last;
  } char_info_t;

endpackage

`default_nettype wire

### rtl/core/aitc_front.sv
// Front of the address text classifier: decodes each incoming character
// into a char_info_t beat for the queue.
// Depends on aitc_pkg.
`default_nettype none

module aitc_front import aitc_pkg::*; (
  input  wire logic [7:0] char_in,
  input  wire logic       is_last,
  output char_info_t      info
);

  logic is_digit;
  logic is_lower_hex;
  logic is_upper_hex;
  logic [7:0] digit_full;

  // Classify the character
  always_comb begin
    is_digit     = (char_in >= CH_0) && (char_in <= CH_9);
    is_lower_hex = (char_in >= CH_LA) && (char_in <= CH_LF);
    is_upper_hex = (char_in >= CH_UA) && (char_in <= CH_UF);
    digit_full   = char_in - CH_0;

    info.is_dot   = (char_in == CH_DOT);
    info.is_colon = (char_in == CH_COLON);
    info.is_digit = is_digit;
    info.is_hex   = is_digit || is_lower_hex || is_upper_hex;
    info.is_zero  = (char_in == CH_0);
    info.digit    = is_digit ? digit_full[3:0] : 4'd0;
    info.last     = is_last;
  end

endmodule

`default_nettype wire

### rtl/core/aitc_queue.sv
// Short queue of decoded characters between front and back.
// Depends on aitc_pkg.
`default_nettype none

module aitc_queue import aitc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire char_info_t wr_data,
  output logic      q_full,
  output logic      q_valid,
  input  wire logic rd_en,
  output char_info_t rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  char_info_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok;
  logic             pop_ok;

  assign q_full  = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign rd_data = slot_r[rd_ptr_r];
  assign push_ok = wr_en && !q_full;
  assign pop_ok  = rd_en && q_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue occupancy beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !pop_ok) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue occupancy did not grow on push");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_ok && !push_ok) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue occupancy did not shrink on pop");
`endif

endmodule

`default_nettype wire

### rtl/core/aitc_back.sv
// Back of the address text classifier: runs the segment state per decoded
// beat and holds the class in an output register until it is popped.
// Depends on aitc_pkg.
`default_nettype none

module aitc_back import aitc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   head_valid,
  input  wire char_info_t head,
  output logic        head_take,
  output logic        res_valid,
  output addr_class_t res_class,
  input  wire logic   res_pop
);

  logic [COUNT_W-1:0] seg_count_r, seg_count_nxt;
  logic [LEN_W-1:0]   seg_len_r, seg_len_nxt;
  logic [VALUE_W-1:0] seg_val_r, seg_val_nxt;
  logic               lead_zero_r, lead_zero_nxt;
  logic               v4_ok_r, v4_ok_nxt;
  logic               v6_ok_r, v6_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  addr_class_t        out_class_r, out_class_nxt;

  logic [VALUE_W+3:0] prod;
  logic               cur_v4_seg;
  logic               cur_v6_seg;
  logic               fin_v4_seg;
  logic               fin_v6_seg;
  logic               slot_free;

  function automatic logic v4_seg_ok(input logic [LEN_W-1:0] len,
                                     input logic lz,
                                     input logic [VALUE_W-1:0] val);
    logic ok;
    ok = (len >= 3'd1) && (len <= 3'd3) && !((len > 3'd1) && lz) &&
         (val <= V4_SEG_MAX);
    return ok;
  endfunction

  function automatic logic v6_seg_ok(input logic [LEN_W-1:0] len);
    logic ok;
    ok = (len >= 3'd1) && (len <= 3'd4);
    return ok;
  endfunction

  // Take a beat when one is valid; take a final beat only when the output slot can hold its result
  assign slot_free = !out_valid_r || res_pop;
  assign head_take = head_valid && (!head.last || slot_free);

  // Update segment state for the head beat
  always_comb begin
    seg_count_nxt = seg_count_r;
    seg_len_nxt   = seg_len_r;
    seg_val_nxt   = seg_val_r;
    lead_zero_nxt = lead_zero_r;
    v4_ok_nxt     = v4_ok_r;
    v6_ok_nxt     = v6_ok_r;
    cur_v4_seg    = v4_seg_ok(seg_len_r, lead_zero_r, seg_val_r);
    cur_v6_seg    = v6_seg_ok(seg_len_r);
    prod = ({4'd0, seg_val_r} << 3) + ({4'd0, seg_val_r} << 1) + {10'd0, head.digit};

    if (head.is_dot || head.is_colon) begin
      if (head.is_dot) begin
        v4_ok_nxt = v4_ok_r && cur_v4_seg;
        v6_ok_nxt = 1'b0;
      end else begin
        v6_ok_nxt = v6_ok_r && cur_v6_seg;
        v4_ok_nxt = 1'b0;
      end
      if (seg_count_r != COUNT_MAX) begin
        seg_count_nxt = seg_count_r + 1'b1;
      end
      seg_len_nxt   = '0;
      seg_val_nxt   = '0;
      lead_zero_nxt = 1'b0;
    end else begin
      if (!head.is_digit) begin
        v4_ok_nxt = 1'b0;
      end
      if (!head.is_hex) begin
        v6_ok_nxt = 1'b0;
      end
      if (seg_len_r == '0) begin
        lead_zero_nxt = head.is_zero;
      end
      if (seg_len_r != LEN_MAX) begin
        seg_len_nxt = seg_len_r + 1'b1;
      end
      if (head.is_digit) begin
        seg_val_nxt = (prod > {4'd0, VALUE_MAX}) ? VALUE_MAX : prod[VALUE_W-1:0];
      end
    end
  end

  // Classify the whole string from the updated state
  always_comb begin
    fin_v4_seg    = v4_seg_ok(seg_len_nxt, lead_zero_nxt, seg_val_nxt);
    fin_v6_seg    = v6_seg_ok(seg_len_nxt);
    out_valid_nxt = out_valid_r && !res_pop;
    out_class_nxt = out_class_r;
    if (head_take && head.last) begin
      out_valid_nxt = 1'b1;
      if (v4_ok_nxt && fin_v4_seg && (seg_count_nxt == V4_SEPS)) begin
        out_class_nxt = CLASS_V4;
      end else if (v6_ok_nxt && fin_v6_seg && (seg_count_nxt == V6_SEPS)) begin
        out_class_nxt = CLASS_V6;
      end else begin
        out_class_nxt = CLASS_NONE;
      end
    end
  end

  // Hold state; clear it after the last beat of a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= '0;
      seg_len_r   <= '0;
      seg_val_r   <= '0;
      lead_zero_r <= 1'b0;
      v4_ok_r     <= 1'b1;
      v6_ok_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (head_take) begin
        if (head.last) begin
          seg_count_r <= '0;
          seg_len_r   <= '0;
          seg_val_r   <= '0;
          lead_zero_r <= 1'b0;
          v4_ok_r     <= 1'b1;
          v6_ok_r     <= 1'b1;
        end else begin
          seg_count_r <= seg_count_nxt;
          seg_len_r   <= seg_len_nxt;
          seg_val_r   <= seg_val_nxt;
          lead_zero_r <= lead_zero_nxt;
          v4_ok_r     <= v4_ok_nxt;
          v6_ok_r     <= v6_ok_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_class_r <= out_class_nxt;
  end

  assign res_valid = out_valid_r;
  assign res_class = out_class_r;

`ifndef NO_ASSERTIONS
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(head_take && head.last))
    else $error("result appeared without a final beat");

  a_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (head_take && head.last) |=> (seg_count_r == '0 && seg_len_r == '0 &&
                                  v4_ok_r && v6_ok_r))
    else $error("segment state not cleared after final beat");

  a_dot_kills_v6: assert property (@(posedge clk) disable iff (!rst_n)
    (head_take && !head.last && head.is_dot) |=> !v6_ok_r)
    else $error("dot separator left IPv6 possible");
`endif

endmodule

`default_nettype wire

### rtl/core/ip_address_text_classifier_unit.sv
// Top level of the address text classifier: front decoder, beat queue and
// back state machine with its output register.
// Depends on aitc_pkg, aitc_front, aitc_queue, aitc_back.
`default_nettype none

// Classifies an address string fed one character per beat, with in_is_last
// set on the final character, as dotted IPv4, colon IPv6 or neither; one
// class comes out per string, in string order. The block takes a character
// every cycle while full is low. The front decodes each character into a
// queue of QUEUE_DEPTH beats; the back updates the segment state for one
// beat per cycle unless a final beat waits on the output register, so
// sustained throughput is one character per cycle while nothing is stalled.
// A class passes a queue slot and then the output register before it is on
// out_addr_class. A waiting class stalls only final characters; others keep
// draining into the segment state while the queue absorbs the rest.

module ip_address_text_classifier_unit import aitc_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_is_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      out_addr_class
);

  char_info_t  front_info;
  char_info_t  head_info;
  logic        head_valid;
  logic        head_take;
  logic        res_valid;
  addr_class_t res_class;

  // Decode the incoming character
  aitc_front u_front (
    .char_in (in_char_in),
    .is_last (in_is_last),
    .info    (front_info)
  );

  // Buffer decoded beats between front and back
  aitc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_info),
    .q_full  (full),
    .q_valid (head_valid),
    .rd_en   (head_take),
    .rd_data (head_info)
  );

  // Run the segment state and hold the result
  aitc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head_info),
    .head_take  (head_take),
    .res_valid  (res_valid),
    .res_class  (res_class),
    .res_pop    (pop)
  );

  assign empty          = !res_valid;
  assign out_addr_class = res_class;

endmodule

`default_nettype wire
